FILE: rtl/clt_pkg.sv
// shared constants, character classes and field codes of the command line tokenizer
package clt_pkg;

   // control codes
   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_DEL   = 8'd127;

   // class bounds
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPP_A = 8'h41;
   localparam logic [7:0] CHAR_UPP_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

   // result field widths
   localparam int LEN_W   = 7;
   localparam int COUNT_W = 3;
   localparam int INDEX_W = 3;
   localparam int START_W = 7;
   localparam int VALUE_W = 32;

   // rsp_tuser bit positions
   localparam int USER_VALID_BIT   = 0;
   localparam int USER_NUMERIC_BIT = 1;

   // field type codes
   localparam logic FIELD_ALPHA   = 1'b0;
   localparam logic FIELD_NUMERIC = 1'b1;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CHAR_UPP_A) && (c <= CHAR_UPP_Z)) ||
             ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

FILE: rtl/clt_ram.sv
// generic simple dual-port ram with one write port and a registered read port
module clt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/clt_walk.sv
// line walker: scans the stored line, records fields in the field ram and emits result beats
module clt_walk #(
   parameter int LINE_CHARS  = 80,
   parameter int FIELD_LIMIT = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [$clog2(LINE_CHARS+1)-1:0]       start_len,
   output logic [$clog2(LINE_CHARS)-1:0]         line_rd_addr,
   input  logic [7:0]                            line_rd_data,
   output logic                                  walk_done,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [55:0]                           rsp_tdata,
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int AW    = $clog2(LINE_CHARS);
   localparam int CW    = $clog2(LINE_CHARS + 1);
   localparam int FW    = FIELD_LIMIT > 1 ? $clog2(FIELD_LIMIT) : 1;
   localparam int NW    = $clog2(FIELD_LIMIT + 1);
   localparam int VW    = clt_pkg::VALUE_W;
   localparam int REC_W = 1 + AW + VW;

   typedef enum logic [2:0] {
      W_IDLE, W_SCAN, W_FLUSH, W_RD, W_LD, W_HOLD
   } walk_state_type;

   walk_state_type state_ff, state_in;

   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] ev_pos_ff, ev_pos_in;
   logic          dv_ff, dv_in;
   logic          alpha_ff, alpha_in;
   logic          digit_ff, digit_in;
   logic          acc_ff, acc_in;
   logic          pend_ff, pend_in;
   logic          type_ff, type_in;
   logic [AW-1:0] start_ff, start_in;
   logic [VW-1:0] val_ff, val_in;
   logic [NW-1:0] found_ff, found_in;
   logic [NW-1:0] k_ff, k_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [clt_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                          rsp_fvalid_ff, rsp_fvalid_in;
   logic [clt_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                          rsp_numeric_ff, rsp_numeric_in;
   logic [clt_pkg::START_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [VW-1:0]                 rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic             fr_we;
   logic [FW-1:0]    fr_wa;
   logic [REC_W-1:0] fr_wd;
   logic [REC_W-1:0] fr_rd;
   logic [NW-1:0]    found_m1;

   logic          c_letter, c_digit;
   logic [VW-1:0] c_val, acc_val;
   logic          open_fld, open_type, scan_stop, issue;

   assign c_letter = clt_pkg::is_letter(line_rd_data);
   assign c_digit  = clt_pkg::is_digit(line_rd_data);
   assign c_val    = VW'(line_rd_data[3:0]);
   // times ten plus the new digit, wraps modulo 2^32
   assign acc_val  = (val_ff << 3) + (val_ff << 1) + c_val;
   assign found_m1 = found_ff - NW'(1);

   assign line_rd_addr = rd_ptr_ff[AW-1:0];

   clt_ram #(
      .WIDTH(REC_W),
      .DEPTH(FIELD_LIMIT)
   ) u_field_ram (
      .clock  (clock),
      .wr_en  (fr_we),
      .wr_addr(fr_wa),
      .wr_data(fr_wd),
      .rd_addr(k_ff[FW-1:0]),
      .rd_data(fr_rd)
   );

   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      rd_ptr_in      = rd_ptr_ff;
      ev_pos_in      = ev_pos_ff;
      dv_in          = 1'b0;
      alpha_in       = alpha_ff;
      digit_in       = digit_ff;
      acc_in         = acc_ff;
      pend_in        = pend_ff;
      type_in        = type_ff;
      start_in       = start_ff;
      val_in         = val_ff;
      found_in       = found_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_fvalid_in  = rsp_fvalid_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_numeric_in = rsp_numeric_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      fr_we          = 1'b0;
      fr_wa          = found_m1[FW-1:0];
      fr_wd          = {type_ff, start_ff, val_ff};
      walk_done      = 1'b0;
      open_fld       = 1'b0;
      open_type      = clt_pkg::FIELD_ALPHA;
      scan_stop      = 1'b0;
      issue          = rd_ptr_ff != len_ff;

      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               len_in    = start_len;
               rd_ptr_in = '0;
               alpha_in  = 1'b0;
               digit_in  = 1'b0;
               acc_in    = 1'b0;
               pend_in   = 1'b0;
               found_in  = '0;
               state_in  = W_SCAN;
            end
         end
         W_SCAN: begin
            if (dv_ff) begin
               if (found_ff == NW'(FIELD_LIMIT)) begin
                  // table full: only finish the digits of the last numeric field
                  if (acc_ff && c_digit) begin
                     val_in = acc_val;
                  end else begin
                     scan_stop = 1'b1;
                  end
               end else if (c_letter) begin
                  acc_in = 1'b0;
                  if (!alpha_ff) begin
                     alpha_in  = 1'b1;
                     open_fld  = 1'b1;
                     open_type = clt_pkg::FIELD_ALPHA;
                  end
               end else if (c_digit) begin
                  if (!digit_ff) begin
                     digit_in  = 1'b1;
                     open_fld  = 1'b1;
                     open_type = clt_pkg::FIELD_NUMERIC;
                  end else if (acc_ff) begin
                     val_in = acc_val;
                  end
               end else begin
                  alpha_in = 1'b0;
                  digit_in = 1'b0;
                  acc_in   = 1'b0;
               end
            end
            if (open_fld) begin
               // retire the previous field, start collecting the new one
               fr_we    = pend_ff;
               pend_in  = 1'b1;
               type_in  = open_type;
               start_in = ev_pos_ff;
               val_in   = (open_type == clt_pkg::FIELD_NUMERIC) ? c_val : '0;
               acc_in   = open_type == clt_pkg::FIELD_NUMERIC;
               found_in = found_ff + NW'(1);
            end
            if (scan_stop || (!dv_ff && !issue)) begin
               state_in = W_FLUSH;
            end else if (issue) begin
               dv_in     = 1'b1;
               ev_pos_in = rd_ptr_ff[AW-1:0];
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
         end
         W_FLUSH: begin
            fr_we = pend_ff;
            k_in  = '0;
            if (found_ff == '0) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = '0;
               rsp_fvalid_in  = 1'b0;
               rsp_index_in   = '0;
               rsp_numeric_in = 1'b0;
               rsp_start_in   = '0;
               rsp_value_in   = '0;
               rsp_last_in    = 1'b1;
               state_in       = W_HOLD;
            end else begin
               state_in = W_RD;
            end
         end
         W_RD: begin
            state_in = W_LD;
         end
         W_LD: begin
            rsp_valid_in   = 1'b1;
            rsp_count_in   = clt_pkg::COUNT_W'(found_ff);
            rsp_fvalid_in  = 1'b1;
            rsp_index_in   = clt_pkg::INDEX_W'(k_ff);
            rsp_numeric_in = fr_rd[REC_W-1];
            rsp_start_in   = clt_pkg::START_W'(fr_rd[VW +: AW]);
            rsp_value_in   = fr_rd[VW-1:0];
            rsp_last_in    = (k_ff + NW'(1)) == found_ff;
            state_in       = W_HOLD;
         end
         W_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  walk_done = 1'b1;
                  state_in  = W_IDLE;
               end else begin
                  k_in     = k_ff + NW'(1);
                  state_in = W_RD;
               end
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff         <= len_in;
      rd_ptr_ff      <= rd_ptr_in;
      ev_pos_ff      <= ev_pos_in;
      alpha_ff       <= alpha_in;
      digit_ff       <= digit_in;
      acc_ff         <= acc_in;
      pend_ff        <= pend_in;
      type_ff        <= type_in;
      start_ff       <= start_in;
      val_ff         <= val_in;
      found_ff       <= found_in;
      k_ff           <= k_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_fvalid_ff  <= rsp_fvalid_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_numeric_ff <= rsp_numeric_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_value_ff, rsp_start_ff, rsp_index_ff, rsp_count_ff,
                        clt_pkg::LEN_W'(len_ff)};
   assign rsp_tuser  = {rsp_numeric_ff, rsp_fvalid_ff};

endmodule

FILE: rtl/command_line_tokenizer.sv
// top level of the command line tokenizer: line editor, line ram and walker
//
// Each received character beat edits the line held in the line ram:
// backspace and delete drop the last character, codes from space upwards are
// appended, other control codes are ignored. A carriage return, or the character
// that fills the line to LINE_CHARS, finishes it; from that beat the input stays
// not ready until the last result beat of the line has been taken. The walk reads
// the line ram once per character, pipelined, and stops early once FIELD_LIMIT
// fields are recorded and the last one's digits are done. Each result beat is then
// read back from the field ram through W_RD and W_LD and held in W_HOLD until it
// is taken; a line without fields gives a single result with field_valid low.
module command_line_tokenizer #(
   parameter int LINE_CHARS  = 80,
   parameter int FIELD_LIMIT = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [6:0] line_length, [9:7] field_count,
                                    // [12:10] field_index, [19:13] field_start,
                                    // [51:20] field_value, [55:52] zero
   output logic [1:0]  rsp_tuser,   // [0] field_valid, [1] field_is_numeric
   output logic        rsp_tlast    // last
);

   localparam int AW = $clog2(LINE_CHARS);
   localparam int CW = $clog2(LINE_CHARS + 1);

   logic [CW-1:0] char_count_ff, char_count_in;
   logic          busy_ff, busy_in;

   logic          accept, is_erase, is_cr, is_print, finish;
   logic [CW-1:0] store_cnt, fin_len;
   logic [AW-1:0] line_rd_addr;
   logic [7:0]    line_rd_data;
   logic          walk_done;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign is_erase   = (req_tdata == clt_pkg::CHAR_BS) || (req_tdata == clt_pkg::CHAR_DEL);
   assign is_cr      = req_tdata == clt_pkg::CHAR_CR;
   assign is_print   = (req_tdata >= clt_pkg::CHAR_SPACE) && !is_erase;
   assign store_cnt  = char_count_ff + CW'(1);
   assign finish     = accept && (is_cr || (is_print && (store_cnt == CW'(LINE_CHARS))));
   assign fin_len    = is_cr ? char_count_ff : store_cnt;

   always_comb begin
      char_count_in = char_count_ff;
      busy_in       = busy_ff;
      if (finish) begin
         char_count_in = '0;
         busy_in       = 1'b1;
      end else if (accept && is_erase && (char_count_ff != '0)) begin
         char_count_in = char_count_ff - CW'(1);
      end else if (accept && is_print) begin
         char_count_in = store_cnt;
      end
      if (walk_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         busy_ff       <= 1'b0;
      end else begin
         char_count_ff <= char_count_in;
         busy_ff       <= busy_in;
      end
   end

   clt_ram #(
      .WIDTH(8),
      .DEPTH(LINE_CHARS)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (accept && is_print),
      .wr_addr(char_count_ff[AW-1:0]),
      .wr_data(req_tdata),
      .rd_addr(line_rd_addr),
      .rd_data(line_rd_data)
   );

   clt_walk #(
      .LINE_CHARS (LINE_CHARS),
      .FIELD_LIMIT(FIELD_LIMIT)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .start       (finish),
      .start_len   (fin_len),
      .line_rd_addr(line_rd_addr),
      .line_rd_data(line_rd_data),
      .walk_done   (walk_done),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // no new character while a line's results are out
   a_no_accept_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a result beat is pending");

   // a carriage return always hands the line to the walker
   a_cr_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata == clt_pkg::CHAR_CR)) |=> !req_tready)
      else $error("carriage return did not finish the line");

   // the empty-line result is the only beat of its line
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[clt_pkg::USER_VALID_BIT]) |-> rsp_tlast)
      else $error("result without a field is not the last beat");

   // a result beat stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result beat changed before it was taken");

endmodule

FILE: test/testbench.sv
// self-checking testbench for the command line tokenizer: line editing, field walk and stalls
`timescale 1ns / 100ps

module testbench;

   localparam int LINE_CHARS    = 80;
   localparam int FIELD_LIMIT   = 5;
   localparam int SETTLE_CYCLES = 200;
   localparam int PHASE_ITEMS   = 24;

   // control codes that the editor drops without effect
   localparam logic [7:0] CHAR_NUL = 8'd0;
   localparam logic [7:0] CHAR_US  = 8'd31;

   typedef enum logic [1:0] {CLASS_LETTER, CLASS_DIGIT, CLASS_OTHER} char_class_type;

   typedef struct {
      logic [clt_pkg::LEN_W-1:0]   line_length;
      logic [clt_pkg::COUNT_W-1:0] field_count;
      logic                        field_valid;
      logic [clt_pkg::INDEX_W-1:0] field_index;
      logic                        field_is_numeric;
      logic [clt_pkg::START_W-1:0] field_start;
      logic [clt_pkg::VALUE_W-1:0] field_value;
      logic                        is_last;
   } field_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] rx_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;          // [6:0] line_length, [9:7] field_count,
                                    // [12:10] field_index, [19:13] field_start,
                                    // [51:20] field_value, [55:52] zero
   logic [1:0]  rsp_tuser;          // [0] field_valid, [1] field_is_numeric
   logic        rsp_tlast;          // last

   // line held by the predictor and the field beats it still expects
   logic [7:0]     line_buf [LINE_CHARS];
   int             line_len = 0;
   field_beat_type expected_fields [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;
   int chars_sent = 0;
   int items_counted = 0;
   int lines_finished = 0;
   int beats_checked = 0;

   command_line_tokenizer #(
      .LINE_CHARS(LINE_CHARS),
      .FIELD_LIMIT(FIELD_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic char_class_type char_class(logic [7:0] c);
      if ((c >= clt_pkg::CHAR_UPP_A && c <= clt_pkg::CHAR_UPP_Z) ||
          (c >= clt_pkg::CHAR_LOW_A && c <= clt_pkg::CHAR_LOW_Z))
         return CLASS_LETTER;
      if (c >= clt_pkg::CHAR_ZERO && c <= clt_pkg::CHAR_NINE)
         return CLASS_DIGIT;
      return CLASS_OTHER;
   endfunction

   // atoi of the digit run from pos, wrapping at 32 bits
   function automatic logic [clt_pkg::VALUE_W-1:0] digit_run_value(int pos);
      logic [clt_pkg::VALUE_W-1:0] v;
      v = '0;
      while (pos < line_len && char_class(line_buf[pos]) == CLASS_DIGIT) begin
         v = v * 32'd10 + {24'd0, line_buf[pos] - clt_pkg::CHAR_ZERO};
         pos++;
      end
      return v;
   endfunction

   task automatic finish_line();
      field_beat_type beat;
      logic           alpha_open;
      logic           digit_open;
      int             found;
      logic           kind [FIELD_LIMIT];
      int             start [FIELD_LIMIT];
      char_class_type cls;
      found = 0;
      alpha_open = 1'b0;
      digit_open = 1'b0;
      for (int i = 0; i < line_len && found < FIELD_LIMIT; i++) begin
         cls = char_class(line_buf[i]);
         if (cls == CLASS_LETTER) begin
            if (!alpha_open) begin
               alpha_open = 1'b1;
               kind[found] = clt_pkg::FIELD_ALPHA;
               start[found] = i;
               found++;
            end
         end else if (cls == CLASS_DIGIT) begin
            if (!digit_open) begin
               digit_open = 1'b1;
               kind[found] = clt_pkg::FIELD_NUMERIC;
               start[found] = i;
               found++;
            end
         end else begin
            alpha_open = 1'b0;
            digit_open = 1'b0;
         end
      end
      beat.line_length = line_len[clt_pkg::LEN_W-1:0];
      if (found == 0) begin
         beat.field_count = '0;
         beat.field_valid = 1'b0;
         beat.field_index = '0;
         beat.field_is_numeric = 1'b0;
         beat.field_start = '0;
         beat.field_value = '0;
         beat.is_last = 1'b1;
         expected_fields.push_back(beat);
      end else begin
         for (int k = 0; k < found; k++) begin
            beat.field_count = found[clt_pkg::COUNT_W-1:0];
            beat.field_valid = 1'b1;
            beat.field_index = k[clt_pkg::INDEX_W-1:0];
            beat.field_is_numeric = kind[k];
            beat.field_start = start[k][clt_pkg::START_W-1:0];
            beat.field_value = (kind[k] == clt_pkg::FIELD_NUMERIC) ?
                               digit_run_value(start[k]) : '0;
            beat.is_last = (k == found - 1);
            expected_fields.push_back(beat);
         end
      end
      line_len = 0;
      lines_finished++;
   endtask

   // apply one accepted character to the predicted line
   task automatic edit_line(logic [7:0] c);
      if (c == clt_pkg::CHAR_BS || c == clt_pkg::CHAR_DEL) begin
         if (line_len > 0)
            line_len--;
         items_counted++;
      end else if (c == clt_pkg::CHAR_CR) begin
         finish_line();
         items_counted++;
      end else if (c >= clt_pkg::CHAR_SPACE) begin
         line_buf[line_len] = c;
         line_len++;
         items_counted++;
         if (line_len == LINE_CHARS)
            finish_line();
      end
   endtask

   task automatic send_char(logic [7:0] c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      edit_line(c);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   // hold the sender off until every expected beat has come out
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_fields.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] random_stored_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 255)); while (c == clt_pkg::CHAR_DEL);
      return c;
   endfunction

   function automatic logic [7:0] random_letter();
      return ($urandom_range(1) ? clt_pkg::CHAR_UPP_A : clt_pkg::CHAR_LOW_A) +
             8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] random_digit();
      return clt_pkg::CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   task automatic send_random_token();
      logic [7:0] c;
      case ($urandom_range(9))
         0, 1, 2: begin
            repeat ($urandom_range(1, 6)) send_char(random_letter());
         end
         3, 4, 5: begin
            // long runs push the value past 32 bits
            repeat ($urandom_range(1, 12)) send_char(random_digit());
         end
         6: begin
            send_char(clt_pkg::CHAR_SPACE);
         end
         7: begin
            send_char(random_stored_byte());
         end
         8: begin
            repeat ($urandom_range(1, 2))
               send_char($urandom_range(1) ? clt_pkg::CHAR_BS : clt_pkg::CHAR_DEL);
         end
         default: begin
            do c = 8'($urandom_range(0, 31));
            while (c == clt_pkg::CHAR_BS || c == clt_pkg::CHAR_CR);
            send_char(c);
         end
      endcase
   endtask

   task automatic test_line_editing();
      send_char(clt_pkg::CHAR_BS);
      send_char(clt_pkg::CHAR_DEL);
      send_char(clt_pkg::CHAR_CR);
      send_char(CHAR_NUL);
      send_char(CHAR_US);
      send_char(8'hFF);
      send_text("z09");
      send_char(clt_pkg::CHAR_BS);
      send_char(clt_pkg::CHAR_DEL);
      send_char(clt_pkg::CHAR_CR);
   endtask

   task automatic test_field_limit();
      send_text("4294967295a-0b-9c");
      send_char(clt_pkg::CHAR_CR);
   endtask

   task automatic test_full_line();
      repeat (40) begin
         case ($urandom_range(2))
            0: send_char(random_letter());
            1: send_char(random_digit());
            default: send_char(random_stored_byte());
         endcase
      end
      send_char(clt_pkg::CHAR_DEL);
      // the line finishes by itself once it holds LINE_CHARS characters
      while (line_len != 0) begin
         case ($urandom_range(2))
            0: send_char(random_letter());
            1: send_char(random_digit());
            default: send_char(random_stored_byte());
         endcase
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int item_goal);
      int first_item;
      int target_len;
      wait_for_drain();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_item = items_counted;
      while (items_counted - first_item < item_goal) begin
         target_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
         while (line_len < target_len)
            send_random_token();
         send_char(clt_pkg::CHAR_CR);
      end
   endtask

   task automatic test_idling_phases();
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(88, 0, PHASE_ITEMS);
      run_phase(0, 88, PHASE_ITEMS);
      run_phase(38, 38, PHASE_ITEMS);
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_beat
      field_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_fields.size() == 0) begin
            $display("%0t: result beat with nothing expected, got tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_fields.pop_front();
            compare_field("line_length", want.line_length, rsp_tdata[6:0]);
            compare_field("field_count", want.field_count, rsp_tdata[9:7]);
            compare_field("field_valid", want.field_valid,
                          rsp_tuser[clt_pkg::USER_VALID_BIT]);
            compare_field("field_index", want.field_index, rsp_tdata[12:10]);
            compare_field("field_is_numeric", want.field_is_numeric,
                          rsp_tuser[clt_pkg::USER_NUMERIC_BIT]);
            compare_field("field_start", want.field_start, rsp_tdata[19:13]);
            compare_field("field_value", want.field_value, rsp_tdata[51:20]);
            compare_field("last", want.is_last, rsp_tlast);
            beats_checked++;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("testbench: timed out with %0d beats outstanding", expected_fields.size());
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_line_editing();
      test_field_limit();
      wait_for_drain();
      test_full_line();
      test_idling_phases();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("testbench: %0d characters sent, %0d lines finished, %0d result beats checked",
               chars_sent, lines_finished, beats_checked);
      $display("testbench: editing codes, field limit, full line and four stall mixes run");
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
